FILE: hdl/assert_macros.svh
// shared assertion macros for the trie engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BTLPM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition that must never be seen outside reset
`define BTLPM_NEVER(lbl, cond, msg) `BTLPM_ASSERT(lbl, !(cond), msg)

`endif

FILE: hdl/btlpm_pkg.sv
package btlpm_pkg;

	localparam int ADDR_W   = 32;
	localparam int PLEN_W   = 6;
	localparam int HOP_W    = 32;
	localparam int PORT_W   = 4;
	localparam int STATUS_W = 2;

	// deepest level a lookup may step from
	localparam logic [PLEN_W-1:0] TOP_LEVEL  = PLEN_W'(31);
	localparam logic [PLEN_W-1:0] MAX_PREFIX = PLEN_W'(32);

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_HIT      = 2'd2,
		ST_MISS     = 2'd3
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
		logic [PLEN_W-1:0] plen;
		logic [HOP_W-1:0]  hop;
		logic [PORT_W-1:0] port;
	} item_t;

	// head of the command queue as seen by the engine
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

endpackage

FILE: hdl/binary_trie_longest_prefix_match_core.sv
// IPv4 longest-prefix-match engine on a one-bit-per-level binary trie. Mode 0 inserts
// the top prefix_len bits of address (prefix_len above 32 counts as 32) with its next
// hop and port, allocating missing nodes from a bump pointer; a repeated prefix
// overwrites its route, and an insert that would need more nodes than remain answers
// status 1 and leaves the trie untouched. Mode 1 walks the address bits while children
// exist and reports the deepest route on the path (a prefix_len 0 route is the default
// that matches everything), status 2 on hit and 3 with zero hop and port on miss.
// Every item gives exactly one result, in order. A two-entry command queue takes
// transfers while the engine works, and a result register holds the answer until its
// transfer. The engine does one dependent node read per trie level through the node
// memory read port, then one node write per allocated node plus one for the route.
// Nothing needs clearing after reset: the root lives in flip-flops and every other node
// is written when it is allocated.
`include "assert_macros.svh"

module binary_trie_longest_prefix_match_core #(
	parameter int NODE_COUNT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command transfer
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [btlpm_pkg::ADDR_W-1:0]     address,
	input  logic [btlpm_pkg::PLEN_W-1:0]     prefix_len,
	input  logic [btlpm_pkg::HOP_W-1:0]      route_next_hop,
	input  logic [btlpm_pkg::PORT_W-1:0]     route_port,
	// result transfer
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [btlpm_pkg::STATUS_W-1:0]   status,
	output logic [btlpm_pkg::HOP_W-1:0]      found_next_hop,
	output logic [btlpm_pkg::PORT_W-1:0]     found_port
);

	btlpm_pkg::q_head_t head;
	logic               pop;

	// front: clamps the prefix length and queues the command
	btlpm_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.address        (address),
		.prefix_len     (prefix_len),
		.route_next_hop (route_next_hop),
		.route_port     (route_port),
		.head           (head),
		.pop            (pop)
	);

	// back: walks and grows the trie, owns the node memory and result register
	btlpm_walk #(
		.NODE_COUNT (NODE_COUNT)
	) u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found_next_hop (found_next_hop),
		.found_port     (found_port)
	);

	// every accepted command must eventually be popped in order; a pop only follows
	// a queued command
	`BTLPM_NEVER(a_pop_empty, pop && !head.valid, "engine took a command from an empty queue")

endmodule

FILE: hdl/btlpm_ram.sv
module btlpm_ram #(
	parameter int WIDTH = 61,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/btlpm_front.sv
`include "assert_macros.svh"

module btlpm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             mode,
	input  logic [btlpm_pkg::ADDR_W-1:0]     address,
	input  logic [btlpm_pkg::PLEN_W-1:0]     prefix_len,
	input  logic [btlpm_pkg::HOP_W-1:0]      route_next_hop,
	input  logic [btlpm_pkg::PORT_W-1:0]     route_port,
	output btlpm_pkg::q_head_t               head,
	input  logic                             pop
);

	btlpm_pkg::item_t entries_q [2];
	btlpm_pkg::item_t item_in;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             do_pop;

	// clamp over-long prefixes to a full host route
	always_comb begin
		item_in.mode    = mode;
		item_in.address = address;
		item_in.plen    = (prefix_len > btlpm_pkg::MAX_PREFIX) ? btlpm_pkg::MAX_PREFIX
			: prefix_len;
		item_in.hop     = route_next_hop;
		item_in.port    = route_port;
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign do_pop     = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= item_in;
		end
	end

	`BTLPM_NEVER(a_q_overflow, cnt_q == 2'd3, "command queue count out of range")
	`BTLPM_ASSERT(a_q_pop_nonempty, pop |-> head.valid || !$past(push),
		"engine popped an empty queue")

endmodule

FILE: hdl/btlpm_walk.sv
`include "assert_macros.svh"

module btlpm_walk #(
	parameter int NODE_COUNT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  btlpm_pkg::q_head_t               head,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [btlpm_pkg::STATUS_W-1:0]   status,
	output logic [btlpm_pkg::HOP_W-1:0]      found_next_hop,
	output logic [btlpm_pkg::PORT_W-1:0]     found_port
);

	localparam int IW = $clog2(NODE_COUNT);
	localparam int FW = $clog2(NODE_COUNT + 1);

	typedef struct packed {
		logic                         has_route;
		logic [btlpm_pkg::HOP_W-1:0]  hop;
		logic [btlpm_pkg::PORT_W-1:0] port;
		logic [IW-1:0]                child1;
		logic [IW-1:0]                child0;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_WALK  = 4'b0010,
		S_ALLOC = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [FW-1:0]                free_q;
	node_t                        root_q;
	logic                         out_valid_q;
	logic [btlpm_pkg::STATUS_W-1:0] status_q;
	logic [btlpm_pkg::HOP_W-1:0]  found_next_hop_q;
	logic [btlpm_pkg::PORT_W-1:0] found_port_q;

	logic                         mode_q;
	logic [btlpm_pkg::ADDR_W-1:0] addr_sh_q;
	logic [btlpm_pkg::PLEN_W-1:0] plen_q;
	logic [btlpm_pkg::HOP_W-1:0]  hop_q;
	logic [btlpm_pkg::PORT_W-1:0] port_q;
	logic [btlpm_pkg::PLEN_W-1:0] level_q;
	node_t                        cur_q;
	logic [IW-1:0]                cur_idx_q;
	logic                         use_rd_q;
	logic                         found_q;
	logic [btlpm_pkg::HOP_W-1:0]  fhop_q;
	logic [btlpm_pkg::PORT_W-1:0] fport_q;
	btlpm_pkg::status_t           res_q;

	logic [NODE_W-1:0]            rd_data;
	node_t                        node;
	logic                         cur_bit;
	logic [IW-1:0]                child;
	logic                         go;
	logic                         take;
	logic                         found_n;
	logic [btlpm_pkg::PLEN_W-1:0] missing;
	logic [FW-1:0]                avail;
	logic                         full;
	logic                         alloc_more;
	node_t                        wr_node;
	logic                         mem_we;
	logic                         root_we;
	logic                         load_out;

	always_comb begin
		node     = use_rd_q ? node_t'(rd_data) : cur_q;
		cur_bit  = addr_sh_q[btlpm_pkg::ADDR_W-1];
		child    = cur_bit ? node.child1 : node.child0;
		if (mode_q == btlpm_pkg::MODE_LOOKUP) begin
			go = (state_q == S_WALK) && (level_q <= btlpm_pkg::TOP_LEVEL) && (child != '0);
		end else begin
			go = (state_q == S_WALK) && (level_q < plen_q) && (child != '0);
		end
		take     = use_rd_q && node.has_route && (mode_q == btlpm_pkg::MODE_LOOKUP);
		found_n  = found_q || take;
		missing  = plen_q - level_q;
		avail    = FW'(NODE_COUNT) - free_q;
		full     = FW'(missing) > avail;

		alloc_more = level_q < plen_q;
		wr_node    = cur_q;
		if (alloc_more) begin
			if (cur_bit) begin
				wr_node.child1 = free_q[IW-1:0];
			end else begin
				wr_node.child0 = free_q[IW-1:0];
			end
		end else begin
			wr_node.has_route = 1'b1;
			wr_node.hop       = hop_q;
			wr_node.port      = port_q;
		end
		mem_we   = (state_q == S_ALLOC) && (cur_idx_q != '0);
		root_we  = (state_q == S_ALLOC) && (cur_idx_q == '0);
		load_out = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	assign pop            = (state_q == S_IDLE) && head.valid;
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_next_hop = found_next_hop_q;
	assign found_port     = found_port_q;

	btlpm_ram #(
		.WIDTH (NODE_W),
		.DEPTH (NODE_COUNT)
	) u_nodes (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cur_idx_q),
		.wdata (wr_node),
		.re    (go),
		.raddr (child),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= FW'(1);
			root_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (root_we) begin
				root_q <= wr_node;
			end
			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (!go) begin
						if (mode_q == btlpm_pkg::MODE_LOOKUP || full) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_ALLOC;
						end
					end
				end
				S_ALLOC: begin
					if (alloc_more) begin
						free_q <= free_q + FW'(1);
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q    <= head.item.mode;
				addr_sh_q <= head.item.address;
				plen_q    <= head.item.plen;
				hop_q     <= head.item.hop;
				port_q    <= head.item.port;
				level_q   <= '0;
				cur_q     <= root_q;
				cur_idx_q <= '0;
				use_rd_q  <= 1'b0;
				found_q   <= (head.item.mode == btlpm_pkg::MODE_LOOKUP) && root_q.has_route;
				if ((head.item.mode == btlpm_pkg::MODE_LOOKUP) && root_q.has_route) begin
					fhop_q  <= root_q.hop;
					fport_q <= root_q.port;
				end else begin
					fhop_q  <= '0;
					fport_q <= '0;
				end
			end
			S_WALK: begin
				cur_q    <= node;
				use_rd_q <= go;
				found_q  <= found_n;
				if (take) begin
					fhop_q  <= node.hop;
					fport_q <= node.port;
				end
				if (go) begin
					cur_idx_q <= child;
					level_q   <= level_q + btlpm_pkg::PLEN_W'(1);
					addr_sh_q <= {addr_sh_q[btlpm_pkg::ADDR_W-2:0], 1'b0};
				end else if (mode_q == btlpm_pkg::MODE_LOOKUP) begin
					res_q <= found_n ? btlpm_pkg::ST_HIT : btlpm_pkg::ST_MISS;
				end else if (full) begin
					res_q <= btlpm_pkg::ST_FULL;
				end
			end
			S_ALLOC: begin
				if (alloc_more) begin
					cur_q     <= '0;
					cur_idx_q <= free_q[IW-1:0];
					level_q   <= level_q + btlpm_pkg::PLEN_W'(1);
					addr_sh_q <= {addr_sh_q[btlpm_pkg::ADDR_W-2:0], 1'b0};
				end else begin
					res_q <= btlpm_pkg::ST_INSERTED;
				end
			end
			default: begin
				if (load_out) begin
					status_q         <= res_q;
					found_next_hop_q <= fhop_q;
					found_port_q     <= fport_q;
				end
			end
		endcase
	end

	`BTLPM_ASSERT(a_free_bound, free_q <= FW'(NODE_COUNT),
		"allocation pointer ran past the node pool")
	`BTLPM_ASSERT(a_free_step, free_q != $past(free_q) |-> free_q == $past(free_q) + FW'(1),
		"allocation pointer moved by more than one node")
	`BTLPM_ASSERT(a_alloc_depth, state_q == S_ALLOC |-> level_q <= plen_q,
		"allocation walked below the prefix length")
	`BTLPM_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == S_OUT),
		"result presented before the walk finished")

endmodule

FILE: tb/sv/tb.sv
module tb;
	import btlpm_pkg::*;

	// trie size of the instance, the predictor keeps a store of the same depth
	localparam int NODES       = 4096;
	// far beyond the slowest legal run: ~1000 items, both sides idling,
	// plus the long hold-off on the result side
	localparam int CYCLE_LIMIT = 500000;
	localparam int IDLE_PCT    = 22;
	localparam int HOLD_CYCLES = 400;

	// one expected result, with the item that caused it for the report
	typedef struct {
		status_t           status;
		logic [HOP_W-1:0]  hop;
		logic [PORT_W-1:0] port;
		item_t             cause;
	} answer_t;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic                mode           = MODE_INSERT;
	logic [ADDR_W-1:0]   address        = '0;
	logic [PLEN_W-1:0]   prefix_len     = '0;
	logic [HOP_W-1:0]    route_next_hop = '0;
	logic [PORT_W-1:0]   route_port     = '0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [HOP_W-1:0]    found_next_hop;
	logic [PORT_W-1:0]   found_port;

	// predictor copy of the trie: per node a route flag, next hop, port and two children
	bit                route_valid [NODES];
	bit [HOP_W-1:0]    route_hop [NODES];
	bit [PORT_W-1:0]   route_if [NODES];
	int unsigned       child_of [NODES][2];
	int unsigned       free_node = 1;

	answer_t           awaited_answers[$];
	logic [ADDR_W-1:0] known_prefixes[$];
	logic [ADDR_W-1:0] cluster_base [6];
	int unsigned       mismatch_count = 0;
	int unsigned       cycle_count    = 0;
	bit                no_gaps        = 1'b0;
	int unsigned       hold_request   = 0;

	binary_trie_longest_prefix_match_core #(
		.NODE_COUNT(NODES)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.address       (address),
		.prefix_len    (prefix_len),
		.route_next_hop(route_next_hop),
		.route_port    (route_port),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.found_next_hop(found_next_hop),
		.found_port    (found_port)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// applies one item to the predicted trie and returns the answer it must produce
	function automatic answer_t predict_answer(input item_t it);
		answer_t     a;
		int unsigned cur;
		int unsigned lvl;
		int unsigned depth;
		int unsigned nxt;
		int unsigned fresh;
		bit          b;

		a.cause  = it;
		a.hop    = '0;
		a.port   = '0;
		cur      = 0;
		lvl      = 0;
		if (it.mode == MODE_INSERT) begin
			// prefix lengths above 32 saturate
			depth = (it.plen > MAX_PREFIX) ? MAX_PREFIX : it.plen;
			while (lvl < depth && child_of[cur][it.address[ADDR_W-1-lvl]] != 0) begin
				cur = child_of[cur][it.address[ADDR_W-1-lvl]];
				lvl++;
			end
			// the whole missing branch must fit, otherwise nothing changes
			if (depth - lvl > NODES - free_node) begin
				a.status = ST_FULL;
			end else begin
				while (lvl < depth) begin
					b                 = it.address[ADDR_W-1-lvl];
					fresh             = free_node;
					free_node++;
					route_valid[fresh] = 1'b0;
					route_hop[fresh]   = '0;
					route_if[fresh]    = '0;
					child_of[fresh][0] = 0;
					child_of[fresh][1] = 0;
					child_of[cur][b]   = fresh;
					cur                = fresh;
					lvl++;
				end
				route_valid[cur] = 1'b1;
				route_hop[cur]   = it.hop;
				route_if[cur]    = it.port;
				a.status         = ST_INSERTED;
			end
		end else begin
			// the root route is the default and matches everything
			a.status = ST_MISS;
			if (route_valid[0]) begin
				a.status = ST_HIT;
				a.hop    = route_hop[0];
				a.port   = route_if[0];
			end
			for (lvl = 0; lvl < ADDR_W; lvl++) begin
				nxt = child_of[cur][it.address[ADDR_W-1-lvl]];
				if (nxt == 0)
					break;
				cur = nxt;
				if (route_valid[cur]) begin
					a.status = ST_HIT;
					a.hop    = route_hop[cur];
					a.port   = route_if[cur];
				end
			end
		end
		return a;
	endfunction

	function automatic item_t make_item(input logic m, input logic [ADDR_W-1:0] a,
			input logic [PLEN_W-1:0] p, input logic [HOP_W-1:0] h,
			input logic [PORT_W-1:0] pt);
		item_t it;

		it.mode    = m;
		it.address = a;
		it.plen    = p;
		it.hop     = h;
		it.port    = pt;
		return it;
	endfunction

	// random item: addresses mostly cluster under a few /16 bases or near earlier
	// prefixes so that lookups run deep and inserts share paths
	function automatic item_t make_random_item();
		item_t       it;
		int unsigned pick;

		it.mode = 1'($urandom_range(0, 1));
		it.hop  = $urandom();
		it.port = PORT_W'($urandom_range(0, 15));
		pick    = $urandom_range(0, 99);
		if (pick < 10 || known_prefixes.size() == 0)
			it.address = $urandom();
		else if (pick < 50)
			it.address = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)]
				^ ($urandom() >> $urandom_range(8, 31));
		else
			it.address = {cluster_base[$urandom_range(0, 5)][31:16], 16'($urandom())};
		pick = $urandom_range(0, 99);
		if (pick < 55)
			it.plen = PLEN_W'($urandom_range(8, 24));
		else if (pick < 85)
			it.plen = PLEN_W'($urandom_range(25, 32));
		else if (pick < 93)
			it.plen = PLEN_W'($urandom_range(0, 7));
		else
			it.plen = PLEN_W'($urandom_range(33, 63));
		if (it.mode == MODE_INSERT && known_prefixes.size() < 256)
			known_prefixes.push_back(it.address);
		return it;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	// one command transfer; valid stays high when the next item follows at once,
	// the prediction is made at the accepting edge so it sees every earlier item
	task automatic send_item(input item_t it);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= it.mode;
		address        <= it.address;
		prefix_len     <= it.plen;
		route_next_hop <= it.hop;
		route_port     <= it.port;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		awaited_answers.push_back(predict_answer(it));
	endtask

	// result side: checks each result transfer and decides ready for the next cycle
	initial begin
		answer_t     want;
		int unsigned hold_left;

		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (awaited_answers.size() == 0) begin
					note_mismatch($sformatf(
						"result transfer with nothing pending: status %0d hop %h port %h",
						status, found_next_hop, found_port));
				end else begin
					want = awaited_answers.pop_front();
					if (status !== want.status || found_next_hop !== want.hop
							|| found_port !== want.port)
						note_mismatch($sformatf(
							"mode %0d addr %h plen %0d: want %s hop %h port %h, got %0d hop %h port %h",
							want.cause.mode, want.cause.address, want.cause.plen,
							want.status.name(), want.hop, want.port,
							status, found_next_hop, found_port));
				end
			end
			// a long hold-off is counted here in cycles
			if (hold_request != 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// empty trie, route without default, default route, nesting, overwrite,
	// the address extremes, saturated prefix lengths and ignored lookup fields
	task automatic test_directed_routes();
		send_item(make_item(MODE_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 4'hF));
		send_item(make_item(MODE_INSERT, 32'h0A01_0200, 6'd24, 32'h0A0A_0A01, 4'h1));
		// nodes on the path but no route on them yet
		send_item(make_item(MODE_LOOKUP, 32'h0A00_0000, 6'd5, 32'h1234_5678, 4'h9));
		send_item(make_item(MODE_LOOKUP, 32'h0A01_02FF, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_INSERT, 32'h0000_0000, 6'd0, 32'hC000_0001, 4'h2));
		send_item(make_item(MODE_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_INSERT, 32'h0A00_0000, 6'd8, 32'h0808_0808, 4'h3));
		// bits below the prefix are don't-care
		send_item(make_item(MODE_INSERT, 32'h0A01_FFFF, 6'd16, 32'h1616_1616, 4'h4));
		send_item(make_item(MODE_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'h0A01_FF00, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'h0AFF_0000, 6'd0, 32'h0, 4'h0));
		// same prefix again replaces the route
		send_item(make_item(MODE_INSERT, 32'h0A01_0000, 6'd16, 32'h5555_AAAA, 4'h5));
		send_item(make_item(MODE_LOOKUP, 32'h0A01_7777, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 4'hF));
		send_item(make_item(MODE_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0000, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 4'h0));
		// lengths above 32 act as 32
		send_item(make_item(MODE_INSERT, 32'h8000_0001, 6'd63, 32'hAAAA_5555, 4'h6));
		send_item(make_item(MODE_LOOKUP, 32'h8000_0001, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'h8000_0000, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_INSERT, 32'hC0A8_0101, 6'd33, 32'hC0A8_01FE, 4'h7));
		// default route with zero hop and port still counts as a hit
		send_item(make_item(MODE_INSERT, 32'hDEAD_BEEF, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'h1234_5678, 6'd0, 32'h0, 4'h0));
		send_item(make_item(MODE_LOOKUP, 32'hC0A8_0101, 6'd0, 32'h0, 4'h0));
	endtask

	task automatic test_random_traffic(input int unsigned count);
		repeat (count)
			send_item(make_random_item());
	endtask

	// a long stretch with no idling on either side
	task automatic test_back_to_back(input int unsigned count);
		no_gaps = 1'b1;
		repeat (count)
			send_item(make_random_item());
		no_gaps = 1'b0;
	endtask

	// result side holds off while commands keep coming, the queue fills and
	// in_ready must drop until results drain again
	task automatic test_output_hold_off(input int unsigned count);
		hold_request = HOLD_CYCLES;
		repeat (count)
			send_item(make_random_item());
	endtask

	// fill the node pool, then hit the exact boundary: one node too many is
	// rejected without change, exactly the remaining nodes are accepted
	task automatic test_pool_exhaustion();
		item_t             it;
		logic [ADDR_W-1:0] a;
		int unsigned       cur;
		int unsigned       depth;
		int unsigned       room;
		int unsigned       guard;

		guard = 0;
		while (NODES - free_node > 20 && guard < 600) begin
			it = make_item(MODE_INSERT, $urandom(),
				(NODES - free_node > 64) ? 6'd32 : 6'($urandom_range(8, 32)),
				$urandom(), PORT_W'($urandom_range(0, 15)));
			send_item(it);
			guard++;
		end
		// look for an address whose missing branch can be sized to what is left
		room  = NODES - free_node;
		guard = 0;
		do begin
			a     = $urandom();
			cur   = 0;
			depth = 0;
			while (depth < ADDR_W && child_of[cur][a[ADDR_W-1-depth]] != 0) begin
				cur = child_of[cur][a[ADDR_W-1-depth]];
				depth++;
			end
			guard++;
		end while (depth + room + 1 > ADDR_W && guard < 1000);
		send_item(make_item(MODE_INSERT, a, 6'(depth + room + 1), $urandom(), 4'hA));
		send_item(make_item(MODE_INSERT, a, 6'(depth + room), $urandom(), 4'hB));
		send_item(make_item(MODE_LOOKUP, a, 6'd0, 32'h0, 4'h0));
		// pool is empty: any new node fails, overwrites still work
		send_item(make_item(MODE_INSERT, ~a, 6'd32, $urandom(), 4'hC));
		send_item(make_item(MODE_INSERT, a, 6'(depth + room), $urandom(), 4'hD));
		send_item(make_item(MODE_INSERT, $urandom(), 6'd0, $urandom(), 4'hE));
		send_item(make_item(MODE_LOOKUP, a, 6'd0, 32'h0, 4'h0));
		repeat (30) begin
			it = make_random_item();
			if ($urandom_range(0, 2) != 0)
				it.mode = MODE_LOOKUP;
			send_item(it);
		end
	endtask

	initial begin
		foreach (cluster_base[i])
			cluster_base[i] = $urandom();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_routes();
		test_random_traffic(600);
		test_back_to_back(150);
		test_output_hold_off(30);
		test_pool_exhaustion();

		// no more command transfers, let every result arrive
		in_valid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		// time for any stray result to show up
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
